// ===== sv/lzkn_pkg.sv =====
// Shared types and constants for the LZKN64 stream decompressor.
// No dependencies; every other file imports this package.
`default_nettype none

package lzkn_pkg;

   localparam int WINDOW_DEPTH_DEF = 1024;
   localparam int TOTAL_BITS_DEF   = 24;
   localparam int QUEUE_DEPTH      = 4;

   localparam int BYTE_W      = 8;
   localparam int COUNT_W     = 9;
   localparam int DIST_W      = 10;
   localparam int OUT_TOTAL_W = 24;
   localparam int SIZE_W      = 32;
   localparam int LIT_W       = 5;

   // command code boundaries
   localparam logic [BYTE_W-1:0] CMD_COPY_MAX = 8'h7F;
   localparam logic [BYTE_W-1:0] CMD_LIT_MAX  = 8'h9F;
   localparam logic [BYTE_W-1:0] CMD_RLE_MAX  = 8'hDF;
   localparam logic [BYTE_W-1:0] CMD_ZERO_EXT = 8'hFF;

   // parser phase
   typedef enum logic [2:0] {
      PH_HEADER,
      PH_CMD,
      PH_DIST,
      PH_LIT,
      PH_RLE,
      PH_ZLEN,
      PH_DONE
   } phase_type;

   typedef enum logic {
      OP_RUN,
      OP_COPY
   } op_kind_type;

   // one work item from parser to executor
   typedef struct packed {
      op_kind_type              kind;
      logic [BYTE_W-1:0]        value;
      logic [COUNT_W-1:0]       count;    // run length, or copy length
      logic [DIST_W-1:0]        copy_dist;
      logic                     end_mark;
      logic                     restart;  // clear history state before this op
   } op_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_FILL,
      BK_COPY_RD,
      BK_COPY_WR
   } back_state_type;

endpackage

`default_nettype wire

// ===== sv/lzkn_front.sv =====
// Command parser: takes compressed bytes, tracks header and stream position,
// and issues run/copy operations. Depends on lzkn_pkg.
`default_nettype none

module lzkn_front (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          accept,
   input  wire [lzkn_pkg::BYTE_W-1:0]   in_byte,
   input  wire                          in_start,
   output logic                         push,
   output lzkn_pkg::op_type             push_op
);
   import lzkn_pkg::*;

   phase_type               phase_ff, phase_in, eff_phase, step_phase;
   logic [1:0]              hcount_ff, hcount_in, eff_hcount;
   logic [SIZE_W-1:0]       size_ff, size_in, eff_size;
   logic [SIZE_W-1:0]       pos_ff, pos_in, eff_pos;
   logic [BYTE_W-1:0]       held_ff, held_in;
   logic [LIT_W-1:0]        lit_ff, lit_in;
   logic                    restart_pend_ff, restart_pend_in;
   logic                    end_hit;
   logic                    has_op;
   op_type                  op;

   // a start byte sees the reset state
   assign eff_phase  = in_start ? PH_HEADER : phase_ff;
   assign eff_hcount = in_start ? 2'd0 : hcount_ff;
   assign eff_size   = in_start ? '0 : size_ff;
   assign eff_pos    = in_start ? '0 : pos_ff;

   // next state
   always_comb begin
      step_phase = eff_phase;
      hcount_in  = eff_hcount;
      size_in    = eff_size;
      held_in    = held_ff;
      lit_in     = lit_ff;
      pos_in     = (&eff_pos) ? eff_pos : eff_pos + 1'b1;
      case (eff_phase)
         PH_HEADER: begin
            size_in = {eff_size[SIZE_W-BYTE_W-1:0], in_byte};
            if (eff_hcount == 2'd3) begin
               hcount_in  = 2'd0;
               step_phase = PH_CMD;
            end else begin
               hcount_in = eff_hcount + 2'd1;
            end
         end
         PH_CMD: begin
            if (in_byte <= CMD_COPY_MAX) begin
               held_in    = in_byte;
               step_phase = PH_DIST;
            end else if (in_byte <= CMD_LIT_MAX) begin
               lit_in = in_byte[LIT_W-1:0];
               if (in_byte[LIT_W-1:0] != '0) begin
                  step_phase = PH_LIT;
               end
            end else if (in_byte <= CMD_RLE_MAX) begin
               held_in    = in_byte;
               step_phase = PH_RLE;
            end else if (in_byte == CMD_ZERO_EXT) begin
               step_phase = PH_ZLEN;
            end
         end
         PH_DIST, PH_RLE, PH_ZLEN: begin
            step_phase = PH_CMD;
         end
         PH_LIT: begin
            lit_in = lit_ff - 1'b1;
            if (lit_ff == LIT_W'(1)) begin
               step_phase = PH_CMD;
            end
         end
         PH_DONE: begin
            pos_in = eff_pos;
         end
         default: begin
            step_phase = PH_DONE;
         end
      endcase
      end_hit  = (step_phase == PH_CMD) && (pos_in >= size_in);
      phase_in = end_hit ? PH_DONE : step_phase;
   end

   // operation outputs
   always_comb begin
      has_op       = 1'b0;
      op.kind      = OP_RUN;
      op.value     = '0;
      op.count     = '0;
      op.copy_dist = {held_ff[1:0], in_byte};
      case (eff_phase)
         PH_CMD: begin
            if (in_byte > CMD_RLE_MAX && in_byte != CMD_ZERO_EXT) begin
               has_op   = 1'b1;
               op.count = COUNT_W'(in_byte[LIT_W-1:0]) + COUNT_W'(2);
            end
         end
         PH_DIST: begin
            has_op   = 1'b1;
            op.kind  = OP_COPY;
            op.count = COUNT_W'(held_ff[6:2]) + COUNT_W'(2);
         end
         PH_LIT: begin
            has_op   = 1'b1;
            op.value = in_byte;
            op.count = COUNT_W'(1);
         end
         PH_RLE: begin
            has_op   = 1'b1;
            op.value = in_byte;
            op.count = COUNT_W'(held_ff[LIT_W-1:0]) + COUNT_W'(2);
         end
         PH_ZLEN: begin
            has_op   = 1'b1;
            op.count = COUNT_W'(in_byte) + COUNT_W'(2);
         end
         default: begin
            has_op = 1'b0;
         end
      endcase
      op.end_mark = end_hit;
      op.restart  = restart_pend_ff || in_start;
      push        = accept && (has_op || end_hit);
      push_op     = op;
      // hold a start until the next op carries it to the executor
      restart_pend_in = restart_pend_ff;
      if (push) begin
         restart_pend_in = 1'b0;
      end else if (accept && in_start) begin
         restart_pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         hcount_ff       <= '0;
         size_ff         <= '0;
         pos_ff          <= '0;
         held_ff         <= '0;
         lit_ff          <= '0;
         restart_pend_ff <= 1'b0;
      end else begin
         restart_pend_ff <= restart_pend_in;
         if (accept) begin
            phase_ff  <= phase_in;
            hcount_ff <= hcount_in;
            size_ff   <= size_in;
            pos_ff    <= pos_in;
            held_ff   <= held_in;
            lit_ff    <= lit_in;
         end
      end
   end

endmodule

`default_nettype wire

// ===== sv/lzkn_queue.sv =====
// Small FIFO of operations between parser and executor.
// Depends on lzkn_pkg.
`default_nettype none

module lzkn_queue #(
   parameter int DEPTH = lzkn_pkg::QUEUE_DEPTH
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  lzkn_pkg::op_type   push_op,
   input  wire                pop,
   output lzkn_pkg::op_type   head_op,
   output logic               full,
   output logic               empty
);
   import lzkn_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   op_type          slot_ff [DEPTH];
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   fill_ff, fill_in;

   assign full    = (fill_ff == CW'(DEPTH));
   assign empty   = (fill_ff == '0);
   assign head_op = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

`default_nettype wire

// ===== sv/lzkn_back.sv =====
// Executor: plays runs and window copies into the history memory and the
// result register, keeps the output byte total. Depends on lzkn_pkg.
`default_nettype none

module lzkn_back #(
   parameter int WINDOW_DEPTH = lzkn_pkg::WINDOW_DEPTH_DEF,
   parameter int TOTAL_BITS   = lzkn_pkg::TOTAL_BITS_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  lzkn_pkg::op_type                  head_op,
   input  wire                               q_empty,
   output logic                              pop,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [lzkn_pkg::BYTE_W-1:0]       rsp_byte,
   output logic [lzkn_pkg::COUNT_W-1:0]      rsp_count,
   output logic                              rsp_last,
   output logic                              rsp_end,
   output logic [lzkn_pkg::OUT_TOTAL_W-1:0]  rsp_total
);
   import lzkn_pkg::*;

   localparam int PW = $clog2(WINDOW_DEPTH);
   localparam int TW = TOTAL_BITS;

   back_state_type       state_ff, state_in;
   logic [BYTE_W-1:0]    hist_mem [WINDOW_DEPTH];
   logic [PW-1:0]        ptr_ff, ptr_in, ptr_base;
   logic                 wrapped_ff, wrapped_in, wrapped_base;
   logic [TW-1:0]        total_ff, total_in, total_base;
   logic [BYTE_W-1:0]    val_ff, val_in;
   logic [COUNT_W-1:0]   remain_ff, remain_in;
   logic [DIST_W-1:0]    dist_ff, dist_in;
   logic                 end_ff, end_in;
   logic                 out_free;
   logic                 mem_we, rd_en;
   logic [PW-1:0]        wr_addr, rd_addr;
   logic [BYTE_W-1:0]    wr_data, rd_data_ff, copy_val;
   logic                 rd_ok_ff, rd_ok_in;
   logic                 rsp_load;
   logic [BYTE_W-1:0]    ld_byte;
   logic [COUNT_W-1:0]   ld_count;
   logic                 ld_last;
   logic [TW:0]          sum;
   logic [COUNT_W-1:0]   add_count;
   logic [TW-1:0]        sat_total;
   logic                 rsp_valid_ff;
   logic [BYTE_W-1:0]    rsp_byte_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;
   logic                 rsp_last_ff, rsp_end_ff;
   logic [OUT_TOTAL_W-1:0] rsp_total_ff;

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign pop          = (state_ff == BK_IDLE) && !q_empty && out_free;
   assign ptr_base     = (pop && head_op.restart) ? '0 : ptr_ff;
   assign wrapped_base = (pop && head_op.restart) ? 1'b0 : wrapped_ff;
   assign total_base   = (pop && head_op.restart) ? '0 : total_ff;
   assign copy_val     = rd_ok_ff ? rd_data_ff : '0;
   assign rd_addr      = ptr_ff - PW'(dist_ff);

   // saturating total
   assign sum       = {1'b0, total_base} + (TW + 1)'(add_count);
   assign sat_total = sum[TW] ? {TW{1'b1}} : sum[TW-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (pop) begin
               if (head_op.kind == OP_COPY) begin
                  state_in = BK_COPY_RD;
               end else if (head_op.count > COUNT_W'(1)) begin
                  state_in = BK_FILL;
               end
            end
         end
         BK_FILL: begin
            if (remain_ff == COUNT_W'(1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_COPY_RD: begin
            state_in = BK_COPY_WR;
         end
         BK_COPY_WR: begin
            if (out_free) begin
               state_in = (remain_ff == COUNT_W'(1)) ? BK_IDLE : BK_COPY_RD;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // datapath controls
   always_comb begin
      ptr_in     = ptr_ff;
      wrapped_in = wrapped_ff;
      total_in   = total_ff;
      val_in     = val_ff;
      remain_in  = remain_ff;
      dist_in    = dist_ff;
      end_in     = end_ff;
      mem_we     = 1'b0;
      wr_addr    = ptr_ff;
      wr_data    = val_ff;
      rd_en      = 1'b0;
      rd_ok_in   = rd_ok_ff;
      rsp_load   = 1'b0;
      ld_byte    = val_ff;
      ld_count   = COUNT_W'(1);
      ld_last    = 1'b1;
      add_count  = COUNT_W'(1);
      case (state_ff)
         BK_IDLE: begin
            if (pop) begin
               ptr_in     = ptr_base;
               wrapped_in = wrapped_base;
               total_in   = total_base;
               val_in     = head_op.value;
               remain_in  = head_op.count;
               dist_in    = head_op.copy_dist;
               end_in     = head_op.end_mark;
               if (head_op.kind == OP_RUN) begin
                  add_count = head_op.count;
                  total_in  = sat_total;
                  rsp_load  = 1'b1;
                  ld_byte   = head_op.value;
                  ld_count  = head_op.count;
                  // first byte of the run goes in right away
                  if (head_op.count != '0) begin
                     mem_we     = 1'b1;
                     wr_addr    = ptr_base;
                     wr_data    = head_op.value;
                     ptr_in     = ptr_base + 1'b1;
                     wrapped_in = wrapped_base || (&ptr_base);
                     remain_in  = head_op.count - 1'b1;
                  end
               end
            end
         end
         BK_FILL: begin
            mem_we     = 1'b1;
            ptr_in     = ptr_ff + 1'b1;
            wrapped_in = wrapped_ff || (&ptr_ff);
            remain_in  = remain_ff - 1'b1;
         end
         BK_COPY_RD: begin
            rd_en    = 1'b1;
            // entries never written since start read as zero
            rd_ok_in = wrapped_ff || (rd_addr < ptr_ff);
         end
         BK_COPY_WR: begin
            if (out_free) begin
               mem_we     = 1'b1;
               wr_data    = copy_val;
               ptr_in     = ptr_ff + 1'b1;
               wrapped_in = wrapped_ff || (&ptr_ff);
               remain_in  = remain_ff - 1'b1;
               total_in   = sat_total;
               rsp_load   = 1'b1;
               ld_byte    = copy_val;
               ld_last    = (remain_ff == COUNT_W'(1));
            end
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         ptr_ff       <= '0;
         wrapped_ff   <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         wrapped_ff   <= wrapped_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_load || (rsp_valid_ff && !rsp_ready);
      end
   end

   always_ff @(posedge clock) begin
      val_ff    <= val_in;
      remain_ff <= remain_in;
      dist_ff   <= dist_in;
      end_ff    <= end_in;
      rd_ok_ff  <= rd_ok_in;
      if (rsp_load) begin
         rsp_byte_ff  <= ld_byte;
         rsp_count_ff <= ld_count;
         rsp_last_ff  <= ld_last;
         rsp_end_ff   <= end_in;
         rsp_total_ff <= OUT_TOTAL_W'(total_in);
      end
   end

   // history memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         hist_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= hist_mem[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_byte  = rsp_byte_ff;
   assign rsp_count = rsp_count_ff;
   assign rsp_last  = rsp_last_ff;
   assign rsp_end   = rsp_end_ff;
   assign rsp_total = rsp_total_ff;

endmodule

`default_nettype wire

// ===== sv/lzkn64_stream_decompressor_top.sv =====
// Path: a run result goes through the op queue and then the result register; a window
// copy result goes through the op queue, the history read register and the result register.
// Throughput: one compressed byte per cycle while the four-entry op queue has room;
// the executor takes a new op only once done with the last: a run is popped with its first
// byte written, then the rest filled; a copy is pop, then history read and write-back per byte.
// Reset: synchronous, active high; clears parser, queue, history pointer, total.
// Top level of the LZKN64 stream decompressor; depends on lzkn_pkg,
// lzkn_front, lzkn_queue and lzkn_back.
`default_nettype none

module lzkn64_stream_decompressor_top #(
   parameter int WINDOW_DEPTH = lzkn_pkg::WINDOW_DEPTH_DEF,
   parameter int TOTAL_BITS   = lzkn_pkg::TOTAL_BITS_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   // compressed byte transactions
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire [lzkn_pkg::BYTE_W-1:0]        req_byte,
   input  wire                               req_start,
   // decompressed run transactions
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [lzkn_pkg::BYTE_W-1:0]       rsp_byte,
   output logic [lzkn_pkg::COUNT_W-1:0]      rsp_count,
   output logic                              rsp_last,
   output logic                              rsp_end,
   output logic [lzkn_pkg::OUT_TOTAL_W-1:0]  rsp_total
);
   import lzkn_pkg::*;

   logic    req_accept;
   logic    push, pop, q_full, q_empty;
   op_type  push_op, head_op;

   // Stall the parser only while the operation queue is full; header, command
   // and trailing bytes push nothing but wait on the same condition.
   assign req_ready  = !q_full;
   assign req_accept = req_valid && req_ready;

   // Front: header, command decode, stream position and end detection.
   lzkn_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .in_byte  (req_byte),
      .in_start (req_start),
      .push     (push),
      .push_op  (push_op)
   );

   // Decouple parser from executor so each can stall on its own.
   lzkn_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (push),
      .push_op (push_op),
      .pop     (pop),
      .head_op (head_op),
      .full    (q_full),
      .empty   (q_empty)
   );

   // Back: history memory, copy engine, result register.
   lzkn_back #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .TOTAL_BITS   (TOTAL_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_op   (head_op),
      .q_empty   (q_empty),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_byte  (rsp_byte),
      .rsp_count (rsp_count),
      .rsp_last  (rsp_last),
      .rsp_end   (rsp_end),
      .rsp_total (rsp_total)
   );

endmodule

`default_nettype wire

// ===== sv/lzkn_checker.sv =====
// Port-level checks for the decompressor top, bound to every instance.
// Depends on lzkn_pkg and lzkn64_stream_decompressor_top.
`default_nettype none

module lzkn_checker (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               rsp_valid,
   input  wire                               rsp_ready,
   input  wire [lzkn_pkg::BYTE_W-1:0]        rsp_byte,
   input  wire [lzkn_pkg::COUNT_W-1:0]       rsp_count,
   input  wire                               rsp_last,
   input  wire                               rsp_end,
   input  wire [lzkn_pkg::OUT_TOTAL_W-1:0]   rsp_total
);
   import lzkn_pkg::*;

   // hold a stalled result transaction
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte) &&
      $stable(rsp_count) && $stable(rsp_last) && $stable(rsp_end) &&
      $stable(rsp_total))
      else $error("result changed while stalled");

   // an empty run is only the bare end marker
   a_empty_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_count == '0 |-> rsp_end && rsp_last && rsp_byte == '0)
      else $error("empty run outside end marker");

   // only window copies give several results per byte, each of one byte
   a_multi_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_count == COUNT_W'(1))
      else $error("non-final result with count other than one");

   // run length bound
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_count <= COUNT_W'(257))
      else $error("run length out of range");

endmodule

bind lzkn64_stream_decompressor_top lzkn_checker u_lzkn_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_byte  (rsp_byte),
   .rsp_count (rsp_count),
   .rsp_last  (rsp_last),
   .rsp_end   (rsp_end),
   .rsp_total (rsp_total)
);

`default_nettype wire

// ===== test/tb_lzkn64_stream_decompressor_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for lzkn64_stream_decompressor_top: a directed stream table, then
// random well-formed and broken streams, each result checked against a built-in decoder.
// Depends on lzkn_pkg and the decompressor RTL.

module tb_lzkn64_stream_decompressor_top;
   import lzkn_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 6;
   localparam int TABLE_ROWS    = 25;
   localparam int RANDOM_ITEMS  = 120;
   localparam int CALM_ITEMS    = 30;
   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HIST_DEPTH    = WINDOW_DEPTH_DEF;

   // saturation point of the running output total
   localparam logic [OUT_TOTAL_W-1:0] TOTAL_MAX =
      OUT_TOTAL_W'((64'd1 << TOTAL_BITS_DEF) - 64'd1);

   // first codes of the command groups, used to build random streams
   localparam logic [BYTE_W-1:0] CMD_LIT_BASE  = 8'h80;
   localparam logic [BYTE_W-1:0] CMD_RLE_BASE  = 8'hA0;  // A0-DF all repeat the next byte
   localparam logic [BYTE_W-1:0] CMD_ZERO_BASE = 8'hE0;

   // one decompressed run as it leaves the block
   typedef struct packed {
      logic [BYTE_W-1:0]      value;
      logic [COUNT_W-1:0]     count;
      logic                   last;
      logic                   stream_end;
      logic [OUT_TOTAL_W-1:0] total;
   } run_type;

   // one directed compressed byte; want is used only where typed is set
   typedef struct packed {
      logic [BYTE_W-1:0] value;
      logic              start;
      logic              typed;
      run_type           want;
   } table_row_type;

   localparam run_type NO_RUN = '0;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [BYTE_W-1:0]      req_byte;
   logic                   req_start;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [BYTE_W-1:0]      rsp_byte;
   logic [COUNT_W-1:0]     rsp_count;
   logic                   rsp_last;
   logic                   rsp_end;
   logic [OUT_TOTAL_W-1:0] rsp_total;

   // decoder state, kept in step with the block
   logic [BYTE_W-1:0]      hist_mem [HIST_DEPTH];
   logic [DIST_W-1:0]      hist_wp;
   phase_type              parse_ph;
   logic [1:0]             hdr_cnt;
   logic [SIZE_W-1:0]      comp_size;
   logic [SIZE_W-1:0]      comp_pos;
   logic [BYTE_W-1:0]      held_cmd;
   logic [LIT_W-1:0]       lits_left;
   logic [OUT_TOTAL_W-1:0] total_out;

   run_type       byte_runs[$];     // runs caused by the byte just decoded
   run_type       pending_runs[$];  // runs still owed by the block, oldest first
   table_row_type directed_rows [TABLE_ROWS];

   int unsigned fail_count;
   int unsigned live_items;     // accepted bytes that the block did not ignore
   int unsigned quiet_cycles;
   int unsigned rsp_hold;
   bit          req_fire;
   bit          calm;           // no idling on either side
   bit          gaps_on;
   bit          drained_mid;
   logic        item_typed;
   run_type     item_want;

   lzkn64_stream_decompressor_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_byte  (req_byte),
      .req_start (req_start),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_byte  (rsp_byte),
      .rsp_count (rsp_count),
      .rsp_last  (rsp_last),
      .rsp_end   (rsp_end),
      .rsp_total (rsp_total)
   );

   initial clock = 1'b0;
   always #HALF_PERIOD clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Decoder
   // ---------------------------------------------------------------------------------------

   function automatic void clear_decoder();
      for (int i = 0; i < HIST_DEPTH; i++) hist_mem[i] = '0;
      hist_wp   = '0;
      parse_ph  = PH_HEADER;
      hdr_cnt   = '0;
      comp_size = '0;
      comp_pos  = '0;
      held_cmd  = '0;
      lits_left = '0;
      total_out = '0;
   endfunction

   // Write a run into the history, bump the saturating total and queue the run.
   function automatic void add_run(input logic [BYTE_W-1:0] val, input int unsigned cnt);
      logic [OUT_TOTAL_W:0] sum;
      run_type              r;
      for (int unsigned i = 0; i < cnt; i++) begin
         hist_mem[hist_wp] = val;
         hist_wp = hist_wp + 1'b1;
      end
      sum = {1'b0, total_out} + (OUT_TOTAL_W + 1)'(cnt);
      total_out = (sum > {1'b0, TOTAL_MAX}) ? TOTAL_MAX : sum[OUT_TOTAL_W-1:0];
      r.value      = val;
      r.count      = COUNT_W'(cnt);
      r.last       = 1'b0;
      r.stream_end = 1'b0;
      r.total      = total_out;
      byte_runs.push_back(r);
   endfunction

   // Decode one compressed byte into byte_runs; return 0 when the byte is ignored.
   function automatic bit decode_byte(input logic [BYTE_W-1:0] b, input logic s);
      logic [DIST_W-1:0] back_dist;
      run_type           r;
      byte_runs.delete();
      if (s) clear_decoder();
      if (parse_ph == PH_DONE) return 1'b0;
      if (comp_pos != '1) comp_pos = comp_pos + 1'b1;
      case (parse_ph)
         PH_HEADER: begin
            comp_size = {comp_size[SIZE_W-9:0], b};
            if (hdr_cnt == 2'd3) begin
               hdr_cnt  = '0;
               parse_ph = PH_CMD;
            end else begin
               hdr_cnt = hdr_cnt + 1'b1;
            end
         end
         PH_CMD: begin
            if (b <= CMD_COPY_MAX) begin
               held_cmd = b;
               parse_ph = PH_DIST;
            end else if (b <= CMD_LIT_MAX) begin
               lits_left = b[LIT_W-1:0];
               if (lits_left != '0) parse_ph = PH_LIT;
            end else if (b <= CMD_RLE_MAX) begin
               held_cmd = b;
               parse_ph = PH_RLE;
            end else if (b == CMD_ZERO_EXT) begin
               parse_ph = PH_ZLEN;
            end else begin
               add_run('0, b[4:0] + 2);
            end
         end
         PH_DIST: begin
            back_dist = {held_cmd[1:0], b};
            // each copied byte reads the history after the previous one went in
            for (int i = 0; i < held_cmd[6:2] + 2; i++)
               add_run(hist_mem[hist_wp - back_dist], 1);
            parse_ph = PH_CMD;
         end
         PH_LIT: begin
            add_run(b, 1);
            lits_left = lits_left - 1'b1;
            if (lits_left == '0) parse_ph = PH_CMD;
         end
         PH_RLE: begin
            add_run(b, held_cmd[4:0] + 2);
            parse_ph = PH_CMD;
         end
         PH_ZLEN: begin
            add_run('0, b + 2);
            parse_ph = PH_CMD;
         end
         default: ;
      endcase
      // the end is only seen between commands
      if (parse_ph == PH_CMD && comp_pos >= comp_size) begin
         parse_ph = PH_DONE;
         if (byte_runs.size() == 0) add_run('0, 0);
         foreach (byte_runs[k]) begin
            r = byte_runs[k];
            r.stream_end = 1'b1;
            byte_runs[k] = r;
         end
      end
      if (byte_runs.size() != 0) begin
         r = byte_runs[byte_runs.size() - 1];
         r.last = 1'b1;
         byte_runs[byte_runs.size() - 1] = r;
      end
      return 1'b1;
   endfunction

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endfunction

   function automatic void item_check(input run_type want);
      check_field("byte", 32'(want.value), 32'(rsp_byte));
      check_field("count", 32'(want.count), 32'(rsp_count));
      check_field("last", 32'(want.last), 32'(rsp_last));
      check_field("end", 32'(want.stream_end), 32'(rsp_end));
      check_field("total", 32'(want.total), 32'(rsp_total));
   endfunction

   // ---------------------------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge, predict, check, watch for a hang
   // ---------------------------------------------------------------------------------------

   always @(posedge clock) begin
      req_fire = req_valid && req_ready && !reset;
      if (!reset) begin
         // decode the accepted byte; a typed table row overrides the decoded runs
         if (req_fire) begin
            if (decode_byte(req_byte, req_start)) live_items++;
            if (item_typed) pending_runs.push_back(item_want);
            else foreach (byte_runs[k]) pending_runs.push_back(byte_runs[k]);
         end
         // compare the accepted run with the oldest one owed
         if (rsp_valid && rsp_ready) begin
            if (pending_runs.size() == 0) begin
               $display("%0t: unexpected run, expected none, actual byte %0h count %0d",
                        $time, rsp_byte, rsp_count);
               fail_count++;
            end else begin
               item_check(pending_runs.pop_front());
            end
         end
         // count cycles in which no transaction happens on either channel
         if (req_fire || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
               $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
               $display("*** FAILED ***");
               $finish;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Receiver: stall in random bursts, none once the run is calm
   // ---------------------------------------------------------------------------------------

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold = 0;
      end else if (rsp_hold != 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         rsp_hold = $urandom_range(0, 4);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------------------------------

   // Present one byte at the falling edge and hold it until the transaction happens.
   task automatic send_item(input logic [BYTE_W-1:0] b, input logic s, input logic typed,
                            input run_type want);
      req_valid  <= 1'b1;
      req_byte   <= b;
      req_start  <= s;
      item_typed <= typed;
      item_want  <= want;
      do @(negedge clock); while (!req_fire);
   endtask

   // Drop valid for a random burst now and then.
   task automatic sender_gap();
      if (!calm && gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
   endtask

   // Hold off the sender until every owed run has come out.
   task automatic drain_all();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_runs.size() != 0);
   endtask

   // Build one random stream: mostly well formed, sometimes cut short, with a wrong size
   // or trailed by stray bytes.
   task automatic send_stream();
      logic [BYTE_W-1:0] body[$];
      logic [SIZE_W-1:0] size;
      int unsigned       target;
      int unsigned       len;
      int unsigned       cut;
      int unsigned       noise;
      logic              first_start;
      target = $urandom_range(4, 40);
      while (body.size() < target) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3);
               // mostly short distances, so copies land on bytes already written
               if ($urandom_range(0, 3) != 0) begin
                  body.push_back({1'b0, len[4:0], 2'b00});
                  body.push_back(8'($urandom_range(1, 32)));
               end else begin
                  body.push_back({1'b0, len[4:0], 2'($urandom_range(0, 3))});
                  body.push_back(8'($urandom_range(0, 255)));
               end
            end
            3, 4, 5: begin
               len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 6);
               body.push_back(CMD_LIT_BASE | 8'(len));
               repeat (len) body.push_back(8'($urandom_range(0, 255)));
            end
            6, 7: begin
               body.push_back(CMD_RLE_BASE + 8'($urandom_range(0, 63)));
               body.push_back(8'($urandom_range(0, 255)));
            end
            8: body.push_back(CMD_ZERO_BASE + 8'($urandom_range(0, 30)));
            default: begin
               body.push_back(CMD_ZERO_EXT);
               body.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                          : 8'($urandom_range(0, 15)));
            end
         endcase
      end
      case ($urandom_range(0, 9))
         0:       size = $urandom_range(0, body.size() + 4);  // ends early, or right away
         1:       size = $urandom();                          // likely never reached
         default: size = body.size() + 4;
      endcase
      cut         = ($urandom_range(0, 7) == 0) ? $urandom_range(0, body.size()) : body.size();
      noise       = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      first_start = ($urandom_range(0, 9) != 0);
      gaps_on     = ($urandom_range(0, 2) != 0);
      for (int i = 3; i >= 0; i--) begin
         send_item(size[8*i +: 8], (i == 3) ? first_start : 1'b0, 1'b0, NO_RUN);
         sender_gap();
      end
      for (int unsigned i = 0; i < cut; i++) begin
         send_item(body[i], 1'b0, 1'b0, NO_RUN);
         sender_gap();
      end
      repeat (noise) begin
         send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, NO_RUN);
         sender_gap();
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------------------

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_byte     = '0;
      req_start    = 1'b0;
      item_typed   = 1'b0;
      item_want    = NO_RUN;
      calm         = 1'b0;
      gaps_on      = 1'b1;
      drained_mid  = 1'b0;
      clear_decoder();

      directed_rows = '{
         // header of size 20, no start mark right after reset
         '{8'h00, 1'b0, 1'b0, NO_RUN},
         '{8'h00, 1'b0, 1'b0, NO_RUN},
         '{8'h00, 1'b0, 1'b0, NO_RUN},
         '{8'h14, 1'b0, 1'b0, NO_RUN},
         // shortest zero run
         '{8'hE0, 1'b0, 1'b1, '{8'h00, 9'd2, 1'b1, 1'b0, 24'd2}},
         // three literals, two of them at the byte extremes
         '{8'h83, 1'b0, 1'b0, NO_RUN},
         '{8'hFF, 1'b0, 1'b1, '{8'hFF, 9'd1, 1'b1, 1'b0, 24'd3}},
         '{8'h00, 1'b0, 1'b1, '{8'h00, 9'd1, 1'b1, 1'b0, 24'd4}},
         '{8'h5A, 1'b0, 1'b1, '{8'h5A, 9'd1, 1'b1, 1'b0, 24'd5}},
         // empty literal command
         '{8'h80, 1'b0, 1'b0, NO_RUN},
         // longest copy, farthest distance, reaching before the first output byte
         '{8'h7F, 1'b0, 1'b0, NO_RUN},
         '{8'hFF, 1'b0, 1'b0, NO_RUN},
         // shortest copy of the previous byte
         '{8'h00, 1'b0, 1'b0, NO_RUN},
         '{8'h01, 1'b0, 1'b0, NO_RUN},
         // longest repeat
         '{8'hDF, 1'b0, 1'b0, NO_RUN},
         '{8'hAB, 1'b0, 1'b0, NO_RUN},
         // longest zero run
         '{8'hFF, 1'b0, 1'b0, NO_RUN},
         '{8'hFF, 1'b0, 1'b0, NO_RUN},
         // distance zero reads a full window back; the stream ends here
         '{8'h00, 1'b0, 1'b0, NO_RUN},
         '{8'h00, 1'b0, 1'b0, NO_RUN},
         // ignored after the end
         '{8'h42, 1'b0, 1'b0, NO_RUN},
         // new stream of size 4: ends after its header with a bare end marker
         '{8'h00, 1'b1, 1'b0, NO_RUN},
         '{8'h00, 1'b0, 1'b0, NO_RUN},
         '{8'h00, 1'b0, 1'b0, NO_RUN},
         '{8'h04, 1'b0, 1'b1, '{8'h00, 9'd0, 1'b1, 1'b1, 24'd0}}
      };

      // hold reset, then release it at a falling edge
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      // walk the directed table, then let the block empty out
      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].value, directed_rows[i].start, directed_rows[i].typed,
                   directed_rows[i].want);
         sender_gap();
      end
      drain_all();

      // random streams until enough live bytes went in; go calm for the last stretch
      while (live_items < TABLE_ROWS + RANDOM_ITEMS) begin
         calm = (live_items >= TABLE_ROWS + RANDOM_ITEMS - CALM_ITEMS);
         send_stream();
         if (!drained_mid && live_items >= TABLE_ROWS + RANDOM_ITEMS / 2) begin
            drain_all();
            drained_mid = 1'b1;
         end
      end

      // wait out every owed run, then settle so that strays show up
      calm = 1'b1;
      drain_all();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
